### sv/drsc_pkg.sv
// Shared types and constants for the drum rhythm style classifier.
// Used by the controller, datapath, divider and top level.
package drsc_pkg;

  localparam int CFG_NUM = 6;
  localparam int CFG_IDX_W = 3;
  localparam int COEF_W = 24;
  localparam int BIN_W = 32;
  localparam int NBINS = 16;
  localparam int BIN_AW = 4;
  localparam int ACC_W = 37;
  localparam int DIV_DW = 37;
  localparam int DIV_NW = 53;
  localparam int Q_W = 16;

  localparam logic [2:0] CFG_LOW_FLOOR = 3'd0;
  localparam logic [2:0] CFG_RELEASE = 3'd5;

  localparam logic [COEF_W-1:0] CFG_RESET [CFG_NUM] = '{
    24'd76690, 24'd239830, 24'd326200, 24'd1267700, 24'd8058800, 24'd11647
  };

  localparam logic [15:0] DECAY_Q16 = 16'd57835;
  localparam logic [15:0] TH_SPARSE = 16'd1147;
  localparam logic [15:0] TH_OPEN = 16'd2867;
  localparam logic [15:0] TH_SYNC = 16'd5325;
  localparam logic [15:0] DANCE_SPAN = 16'd819;
  localparam logic [6:0] MIN_BARS = 7'd4;
  localparam logic [6:0] FULL_BARS = 7'd8;
  localparam logic [6:0] MAX_BARS = 7'd64;
  localparam logic [2:0] SWITCH_BARS = 3'd4;

  typedef enum logic [1:0] {
    STYLE_POP = 2'd0,
    STYLE_ROCK = 2'd1,
    STYLE_DANCE = 2'd2,
    STYLE_MARCHA = 2'd3
  } drsc_style_t;

  typedef enum logic [2:0] {
    DIV_EVEN = 3'd0,
    DIV_ALT = 3'd1,
    DIV_OFF = 3'd2,
    DIV_SYNC = 3'd3,
    DIV_MARGIN = 3'd4
  } drsc_div_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DK_RD, S_DK_MUL, S_DK_WR, S_BARS, S_BRANCH, S_FEW,
    S_OCC, S_DIV_GO, S_DIV_WAIT, S_DECIDE, S_PHASE, S_LP_MUL, S_LP_ADD,
    S_ENV_MUL, S_ENV_ADD, S_BIN_WR
  } drsc_state_t;

  typedef struct packed {
    logic accept;
    logic clr_acc;
    logic dk_rd;
    logic dk_mul;
    logic dk_wr;
    logic bars_upd;
    logic occ_step;
    logic div_start;
    drsc_div_t div_sel;
    logic load_few;
    logic load_dec;
    logic phase_upd;
    logic bin_rd;
    logic lp_mul;
    logic lp_add;
    logic env_mul;
    logic env_add;
    logic bin_wr;
    logic [3:0] idx;
  } drsc_cmd_t;

  typedef struct packed {
    logic wrap;
    logic stable;
    logic bars_ok;
    logic div_done;
    logic out_free;
  } drsc_stat_t;

endpackage

### sv/drsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drsc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/drsc_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit saturated quotient.
// Depends on drsc_pkg.
module drsc_div
  import drsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [Q_W-1:0]    quo
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]    low_r, low_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [DIV_DW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    low_nxt = low_r;
    q_nxt = q_r;
    trial = {rem_r, low_r[Q_W-1]};
    if (start) begin
      if (den == '0) begin
        q_nxt = '0;
        done_nxt = 1'b1;
      end else if (num >= {den, 16'd0}) begin
        q_nxt = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt = num[DIV_NW-1:Q_W];
        low_nxt = num[Q_W-1:0];
        cnt_nxt = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, den});
        q_nxt = {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        q_nxt = {q_r[Q_W-2:0], 1'b0};
      end
      low_nxt = {low_r[Q_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r <= q_nxt;
  end

  assign done = done_r;
  assign quo = q_r;

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r || done_r)) else $error("divider start lost");

endmodule

### sv/drsc_dp.sv
// Datapath: band filters, envelopes, bin store, bar statistics and decision.
// Depends on drsc_pkg, drsc_ram and drsc_div.
module drsc_dp
  import drsc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  drsc_cmd_t                     cmd,
  output drsc_stat_t                    stat,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [15:0]                   in_bar_phase,
  input  logic                          in_stable,
  input  logic                          in_block_start,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_style,
  output logic [15:0]                   out_confidence,
  output logic [15:0]                   out_kick_evenness,
  output logic [15:0]                   out_body_alternation,
  output logic [15:0]                   out_offbeat_hat_ratio,
  output logic [15:0]                   out_syncopation_ratio,
  output logic [4:0]                    out_occupied_bins
);

  localparam int SHIFT = 24 - SAMPLE_BITS;

  // configuration and captured item
  logic [COEF_W-1:0]             cfg_r [CFG_NUM];
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [15:0]                   phase_r;
  logic                          stable_r, start_r;

  // persistent state
  logic signed [23:0] lp_r [5];
  logic [24:0]        env_r [3];
  logic [24:0]        rise_r [3];
  logic [NBINS-1:0]   bin_ok_r;
  logic [15:0]        prev_phase_r;
  drsc_style_t        held_r, rival_r;
  logic [2:0]         rival_bars_r;
  logic [6:0]         bars_r;

  // shared filter multiplier
  logic signed [50:0] prod_r;
  logic signed [25:0] mul_a;
  logic signed [24:0] mul_b;

  // bar statistics
  logic [47:0]  dprod_r [3];
  logic [33:0]  qk_r [4];
  logic [33:0]  qb_r [4];
  logic [33:0]  hon_r, hoff_r, bon_r;
  logic [35:0]  odd_r;
  logic [33:0]  t_r [NBINS];
  logic [33:0]  loud_r;
  logic [4:0]   occ_r;
  logic [15:0]  even_r, alt_r, offr_r, sync_r, marg_r;
  logic         rd_ok_r;

  // output register
  logic        out_valid_r;
  drsc_style_t o_style_r;
  logic [15:0] o_conf_r, o_even_r, o_alt_r, o_off_r, o_sync_r;
  logic [4:0]  o_occ_r;

  logic signed [23:0] x;
  logic [BIN_AW-1:0]  bin_idx;
  logic [95:0]        rdata, wdata;
  logic [BIN_AW-1:0]  raddr, waddr;
  logic [31:0]        old_b [3];
  logic [31:0]        dec_b [3];
  logic [24:0]        env_v;
  logic [24:0]        ab_kick, ab_body, ab_high;
  logic signed [24:0] dk, db, dh;

  assign x = 24'(sample_r) <<< SHIFT;
  assign bin_idx = prev_phase_r[15:12];

  always_comb begin
    dk = 25'(lp_r[1]) - 25'(lp_r[0]);
    db = 25'(lp_r[3]) - 25'(lp_r[2]);
    dh = 25'(x) - 25'(lp_r[4]);
    ab_kick = dk[24] ? 25'(-dk) : 25'(dk);
    ab_body = db[24] ? 25'(-db) : 25'(db);
    ab_high = dh[24] ? 25'(-dh) : 25'(dh);
    case (cmd.idx[1:0])
      2'd0: env_v = ab_kick;
      2'd1: env_v = ab_body;
      default: env_v = ab_high;
    endcase
  end

  // operand select for the one-pole multiplier
  always_comb begin
    if (cmd.lp_mul) begin
      mul_a = 26'(25'(x) - 25'(lp_r[cmd.idx[2:0]]));
      mul_b = $signed({1'b0, cfg_r[cmd.idx[2:0]]});
    end else begin
      mul_a = $signed({1'b0, env_v}) - $signed({1'b0, env_r[cmd.idx[1:0]]});
      mul_b = $signed({1'b0, cfg_r[CFG_RELEASE]});
    end
  end

  // bin store, three bands per word: kick low, body middle, hat high
  assign raddr = cmd.dk_rd ? cmd.idx : bin_idx;
  assign waddr = cmd.dk_wr ? cmd.idx : bin_idx;

  drsc_ram #(.WIDTH(96), .DEPTH(NBINS)) u_bins (
    .clk(clk), .we(cmd.dk_wr || cmd.bin_wr), .waddr(waddr), .wdata(wdata),
    .re(cmd.dk_rd || cmd.bin_rd), .raddr(raddr), .rdata(rdata)
  );

  logic [32:0] bsum [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      old_b[i] = rd_ok_r ? rdata[32*i +: 32] : 32'd0;
      dec_b[i] = dprod_r[i][47:16];
      bsum[i] = {1'b0, old_b[i]} + 33'(rise_r[i]);
    end
    if (cmd.dk_wr) begin
      wdata = {dec_b[2], dec_b[1], dec_b[0]};
    end else begin
      wdata = {bsum[2][32] ? 32'hFFFF_FFFF : bsum[2][31:0],
               bsum[1][32] ? 32'hFFFF_FFFF : bsum[1][31:0],
               bsum[0][32] ? 32'hFFFF_FFFF : bsum[0][31:0]};
    end
  end

  // quarter and group figures
  logic [33:0] lo, hi;
  logic [35:0] tot;
  logic [34:0] qa, qb, qdiff;
  logic [34:0] ev;
  always_comb begin
    lo = qk_r[0];
    hi = qk_r[0];
    for (int i = 1; i < 4; i++) begin
      if (qk_r[i] < lo) lo = qk_r[i];
      if (qk_r[i] > hi) hi = qk_r[i];
    end
    tot = 36'(qb_r[0]) + 36'(qb_r[1]) + 36'(qb_r[2]) + 36'(qb_r[3]);
    qa = 35'(qb_r[0]) + 35'(qb_r[2]);
    qb = 35'(qb_r[1]) + 35'(qb_r[3]);
    qdiff = (qa > qb) ? qa - qb : qb - qa;
    ev = 35'(bon_r) + 35'(hon_r);
  end

  // style pick and margin operands
  drsc_style_t want;
  logic [15:0] m_diff, m_div;
  always_comb begin
    if (offr_r < TH_SPARSE) begin
      want = STYLE_POP;
      m_diff = TH_SPARSE - offr_r;
      m_div = TH_SPARSE;
    end else if (sync_r > TH_SYNC) begin
      want = STYLE_MARCHA;
      m_diff = sync_r - TH_SYNC;
      m_div = TH_SYNC;
    end else if (offr_r > TH_OPEN) begin
      want = STYLE_DANCE;
      m_diff = offr_r - TH_OPEN;
      m_div = DANCE_SPAN;
    end else begin
      want = STYLE_ROCK;
      m_diff = TH_OPEN - offr_r;
      m_div = TH_OPEN;
    end
  end

  logic [DIV_NW-1:0] d_num;
  logic [DIV_DW-1:0] d_den;
  logic              d_done;
  logic [Q_W-1:0]    d_quo;
  always_comb begin
    case (cmd.div_sel)
      DIV_EVEN: begin
        d_num = DIV_NW'(lo) << 12;
        d_den = DIV_DW'(hi);
      end
      DIV_ALT: begin
        d_num = DIV_NW'(qdiff) << 12;
        d_den = DIV_DW'(tot);
      end
      DIV_OFF: begin
        d_num = DIV_NW'(hoff_r) << 12;
        d_den = DIV_DW'(hon_r);
      end
      DIV_SYNC: begin
        d_num = DIV_NW'(odd_r) << 12;
        d_den = DIV_DW'(ev);
      end
      default: begin
        d_num = DIV_NW'(m_diff) << 16;
        d_den = DIV_DW'(m_div);
      end
    endcase
  end

  drsc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(d_num), .den(d_den),
    .done(d_done), .quo(d_quo)
  );

  // hysteresis and score
  drsc_style_t rival_n, held_n;
  logic [2:0]  rb_n;
  logic [19:0] score_w;
  always_comb begin
    held_n = held_r;
    rival_n = rival_r;
    rb_n = rival_bars_r;
    if (want == held_r) begin
      rb_n = '0;
      rival_n = held_r;
    end else begin
      if (want == rival_r) begin
        rb_n = rival_bars_r + 3'd1;
      end else begin
        rival_n = want;
        rb_n = 3'd1;
      end
      if (rb_n >= SWITCH_BARS) begin
        held_n = rival_n;
        rb_n = '0;
      end
    end
    score_w = 20'(marg_r) * 20'((bars_r < FULL_BARS) ? bars_r : FULL_BARS);
  end

  logic [33:0] t_new;
  logic [39:0] t50, l11;
  assign t_new = 34'(dec_b[0]) + 34'(dec_b[1]) + 34'(dec_b[2]);
  assign t50 = (40'(t_r[cmd.idx]) << 5) + (40'(t_r[cmd.idx]) << 4)
             + (40'(t_r[cmd.idx]) << 1);
  assign l11 = (40'(loud_r) << 3) + (40'(loud_r) << 1) + 40'(loud_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_NUM; i++) cfg_r[i] <= CFG_RESET[i];
      for (int i = 0; i < 5; i++) lp_r[i] <= '0;
      for (int i = 0; i < 3; i++) env_r[i] <= '0;
      bin_ok_r <= '0;
      prev_phase_r <= '0;
      held_r <= STYLE_POP;
      rival_r <= STYLE_POP;
      rival_bars_r <= '0;
      bars_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index < CFG_IDX_W'(CFG_NUM))) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      if (cmd.lp_add) begin
        lp_r[cmd.idx[2:0]] <= 24'(lp_r[cmd.idx[2:0]] + 24'(prod_r >>> 24));
      end
      if (cmd.env_add) begin
        env_r[cmd.idx[1:0]] <= 25'($signed({1'b0, env_r[cmd.idx[1:0]]})
                                   + 26'(prod_r >>> 24));
      end
      if (cmd.dk_wr) begin
        bin_ok_r[cmd.idx] <= 1'b1;
      end
      if (cmd.bin_wr) begin
        bin_ok_r[bin_idx] <= 1'b1;
      end
      if (cmd.phase_upd && start_r) begin
        prev_phase_r <= phase_r;
      end
      if (cmd.bars_upd && stable_r && (bars_r < MAX_BARS)) begin
        bars_r <= bars_r + 7'd1;
      end
      if (cmd.load_dec) begin
        held_r <= held_n;
        rival_r <= rival_n;
        rival_bars_r <= rb_n;
      end
      // hold the result until the downstream side takes it
      if (cmd.load_few || cmd.load_dec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      phase_r <= in_bar_phase;
      stable_r <= in_stable;
      start_r <= in_block_start;
    end
    if (cmd.lp_mul || cmd.env_mul) begin
      prod_r <= 51'(mul_a) * 51'(mul_b);
    end
    if (cmd.env_mul) begin
      rise_r[cmd.idx[1:0]] <= (env_v > env_r[cmd.idx[1:0]])
                              ? env_v - env_r[cmd.idx[1:0]] : 25'd0;
    end
    if (cmd.dk_rd || cmd.bin_rd) begin
      rd_ok_r <= bin_ok_r[raddr];
    end
    if (cmd.dk_mul) begin
      for (int i = 0; i < 3; i++) dprod_r[i] <= 48'(old_b[i]) * 48'(DECAY_Q16);
    end
    if (cmd.clr_acc) begin
      for (int i = 0; i < 4; i++) begin
        qk_r[i] <= '0;
        qb_r[i] <= '0;
      end
      hon_r <= '0;
      hoff_r <= '0;
      bon_r <= '0;
      odd_r <= '0;
      loud_r <= '0;
      occ_r <= '0;
    end
    if (cmd.dk_wr) begin
      qk_r[cmd.idx[3:2]] <= qk_r[cmd.idx[3:2]] + 34'(dec_b[0]);
      qb_r[cmd.idx[3:2]] <= qb_r[cmd.idx[3:2]] + 34'(dec_b[1]);
      if (cmd.idx[1:0] == 2'd0) begin
        hon_r <= hon_r + 34'(dec_b[2]);
        bon_r <= bon_r + 34'(dec_b[1]);
      end
      if (cmd.idx[1:0] == 2'd2) begin
        hoff_r <= hoff_r + 34'(dec_b[2]);
      end
      if (cmd.idx[0]) begin
        odd_r <= odd_r + 36'(dec_b[1]) + 36'(dec_b[2]);
      end
      t_r[cmd.idx] <= t_new;
      if (t_new > loud_r) begin
        loud_r <= t_new;
      end
    end
    if (cmd.occ_step && (loud_r != '0) && (t50 > l11)) begin
      occ_r <= occ_r + 5'd1;
    end
    if (d_done) begin
      case (cmd.div_sel)
        DIV_EVEN: even_r <= d_quo;
        DIV_ALT: alt_r <= d_quo;
        DIV_OFF: offr_r <= d_quo;
        DIV_SYNC: sync_r <= d_quo;
        default: marg_r <= d_quo;
      endcase
    end
    if (cmd.load_few) begin
      o_style_r <= held_r;
      o_conf_r <= '0;
      o_even_r <= '0;
      o_alt_r <= '0;
      o_off_r <= '0;
      o_sync_r <= '0;
      o_occ_r <= '0;
    end
    if (cmd.load_dec) begin
      o_style_r <= held_n;
      o_conf_r <= score_w[18:3];
      o_even_r <= even_r;
      o_alt_r <= alt_r;
      o_off_r <= offr_r;
      o_sync_r <= sync_r;
      o_occ_r <= occ_r;
    end
  end

  assign stat.wrap = start_r && (phase_r < prev_phase_r);
  assign stat.stable = stable_r;
  assign stat.bars_ok = (bars_r >= MIN_BARS);
  assign stat.div_done = d_done;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_style = o_style_r;
  assign out_confidence = o_conf_r;
  assign out_kick_evenness = o_even_r;
  assign out_body_alternation = o_alt_r;
  assign out_offbeat_hat_ratio = o_off_r;
  assign out_syncopation_ratio = o_sync_r;
  assign out_occupied_bins = o_occ_r;

  a_rival_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rival_bars_r < SWITCH_BARS) else $error("rival bar count overran");

  a_switch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_r) |-> (rival_bars_r == 3'd0))
    else $error("style switched without clearing rival count");

endmodule

### sv/drsc_ctrl.sv
// Sequencer for the classifier: accept, bar-end sweep, divisions, filtering.
// Depends on drsc_pkg.
module drsc_ctrl
  import drsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  drsc_stat_t stat,
  output drsc_cmd_t  cmd
);

  drsc_state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.idx = cnt_r;
    cmd.div_sel = DIV_MARGIN;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (stat.wrap) begin
          cmd.clr_acc = 1'b1;
          state_nxt = S_DK_RD;
        end else begin
          state_nxt = S_PHASE;
        end
      end
      S_DK_RD: begin
        cmd.dk_rd = 1'b1;
        state_nxt = S_DK_MUL;
      end
      S_DK_MUL: begin
        cmd.dk_mul = 1'b1;
        state_nxt = S_DK_WR;
      end
      S_DK_WR: begin
        cmd.dk_wr = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = (cnt_r == 4'd15) ? S_BARS : S_DK_RD;
      end
      S_BARS: begin
        cmd.bars_upd = 1'b1;
        state_nxt = S_BRANCH;
      end
      S_BRANCH: begin
        cnt_nxt = '0;
        state_nxt = stat.bars_ok ? S_OCC : S_FEW;
      end
      S_FEW: begin
        if (stat.out_free) begin
          cmd.load_few = 1'b1;
          state_nxt = S_PHASE;
        end
      end
      S_OCC: begin
        cmd.occ_step = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          cnt_nxt = '0;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_sel = drsc_div_t'(cnt_r[2:0]);
        cmd.div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        cmd.div_sel = drsc_div_t'(cnt_r[2:0]);
        if (stat.div_done) begin
          cnt_nxt = cnt_r + 4'd1;
          state_nxt = (cnt_r == 4'(DIV_MARGIN)) ? S_DECIDE : S_DIV_GO;
        end
      end
      S_DECIDE: begin
        if (stat.out_free) begin
          cmd.load_dec = 1'b1;
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.phase_upd = 1'b1;
        cnt_nxt = '0;
        state_nxt = stat.stable ? S_LP_MUL : S_IDLE;
      end
      S_LP_MUL: begin
        cmd.lp_mul = 1'b1;
        cmd.bin_rd = 1'b1;
        state_nxt = S_LP_ADD;
      end
      S_LP_ADD: begin
        cmd.lp_add = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd4) begin
          cnt_nxt = '0;
          state_nxt = S_ENV_MUL;
        end else begin
          state_nxt = S_LP_MUL;
        end
      end
      S_ENV_MUL: begin
        cmd.env_mul = 1'b1;
        state_nxt = S_ENV_ADD;
      end
      S_ENV_ADD: begin
        cmd.env_add = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = (cnt_r == 4'd2) ? S_BIN_WR : S_ENV_MUL;
      end
      S_BIN_WR: begin
        cmd.bin_wr = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_CHECK)) else $error("accept did not start work");

endmodule

### sv/drum_rhythm_style_classifier.sv
// Drum rhythm style classifier, top level. One item in flight at a time.
// A stable sample runs the filter and envelope updates; an unstable one skips them. A bar
// wrap first adds a bin decay sweep, then with too few bars a result with zeroed figures,
// or else an occupancy sweep and five divisions before the decision is loaded.
// A new sample is taken only once the last one is done; the multiplier and divider are shared.
// Reset (rst_n low, synchronous) clears the control and filter state and restores the coefficients.
module drum_rhythm_style_classifier
  import drsc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel: one transfer per audio sample
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [15:0]                   in_bar_phase,
  input  logic                          in_stable,
  input  logic                          in_block_start,
  // result channel: one transfer per bar wrap
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_style,
  output logic [15:0]                   out_confidence,
  output logic [15:0]                   out_kick_evenness,
  output logic [15:0]                   out_body_alternation,
  output logic [15:0]                   out_offbeat_hat_ratio,
  output logic [15:0]                   out_syncopation_ratio,
  output logic [4:0]                    out_occupied_bins,
  // coefficient write channel, always ready
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_data
);

  drsc_cmd_t  cmd;
  drsc_stat_t stat;

  // writes to indexes past the last register are dropped in the datapath
  assign cfg_ready = 1'b1;

  // sequencer: steps through decay, decision and per-sample filtering
  drsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  // datapath: holds all state; the result register frees the input side, so
  // a new sample is taken while a finished result still waits downstream
  drsc_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_sample(in_sample), .in_bar_phase(in_bar_phase), .in_stable(in_stable),
    .in_block_start(in_block_start),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_style(out_style),
    .out_confidence(out_confidence), .out_kick_evenness(out_kick_evenness),
    .out_body_alternation(out_body_alternation),
    .out_offbeat_hat_ratio(out_offbeat_hat_ratio),
    .out_syncopation_ratio(out_syncopation_ratio),
    .out_occupied_bins(out_occupied_bins)
  );

endmodule
